@@ rtl/pet_pkg.sv @@
`timescale 1ns / 1ps
package pet_pkg;

  localparam int POSW  = 28;
  localparam int VELW  = 32;
  localparam int TURNW = 32;
  localparam int SW    = 46;
  localparam int AW    = 43;
  localparam int BW_B  = 33;
  localparam int PRODW = 76;
  localparam int DW    = 28;
  localparam int CNTW  = $clog2(PRODW);

  localparam logic [AW-1:0]        LIMIT   = 43'd4398046511104;
  localparam logic [AW-1:0]        MEAS_A  = 43'd268435456;
  localparam logic [DW-1:0]        VEL_DIV = 28'd256;
  localparam logic signed [SW-1:0] TURN_S  = 46'sd268435456;
  localparam logic signed [SW-1:0] HALF_S  = 46'sd134217728;
  localparam logic signed [SW-1:0] LIM_S   = 46'sd4398046511104;
  localparam logic signed [SW-1:0] VMAX_S  = 46'sd2147483647;
  localparam logic signed [SW-1:0] VMIN_S  = -46'sd2147483648;

  localparam logic [2:0] OP_MEAS = 3'd0;
  localparam logic [2:0] OP_DEST = 3'd1;
  localparam logic [2:0] OP_CORR = 3'd2;
  localparam logic [2:0] OP_X    = 3'd3;
  localparam logic [2:0] OP_DV   = 3'd4;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       latch;
    logic       push;
    logic [2:0] op;
  } pet_cmd_t;

  typedef struct packed {
    logic done;
    logic period_zero;
  } pet_stat_t;

endpackage

@@ rtl/pet_mdiv.sv @@
`timescale 1ns / 1ps
module pet_mdiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pet_pkg::AW-1:0]       a_i,
  input  logic [pet_pkg::BW_B-1:0]     b_i,
  input  logic [pet_pkg::DW-1:0]       d_i,
  output logic                         done_o,
  output logic [pet_pkg::AW-1:0]       res_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]                    phase_q, phase_d;
  logic [pet_pkg::CNTW-1:0]      cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [pet_pkg::PRODW-1:0]     a_q, a_d;
  logic [pet_pkg::BW_B-1:0]      b_q, b_d;
  logic [pet_pkg::PRODW-1:0]     prod_q, prod_d;
  logic [pet_pkg::DW-1:0]        d_q, d_d;
  logic [pet_pkg::DW-1:0]        rem_q, rem_d;
  logic [pet_pkg::DW:0]          rem_sh;
  logic                          qbit;

  assign rem_sh = {rem_q, prod_q[pet_pkg::PRODW-1]};
  assign qbit   = (rem_sh >= {1'b0, d_q});

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    a_d     = a_q;
    b_d     = b_q;
    prod_d  = prod_q;
    d_d     = d_q;
    rem_d   = rem_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          a_d     = pet_pkg::PRODW'(a_i);
          b_d     = b_i;
          d_d     = d_i;
          prod_d  = '0;
          cnt_d   = pet_pkg::CNTW'(pet_pkg::BW_B - 1);
          done_d  = 1'b0;
          phase_d = PH_MUL;
        end
      end
      PH_MUL: begin
        if (b_q[0]) begin
          prod_d = prod_q + a_q;
        end
        a_d = {a_q[pet_pkg::PRODW-2:0], 1'b0};
        b_d = {1'b0, b_q[pet_pkg::BW_B-1:1]};
        if (cnt_q == '0) begin
          cnt_d   = pet_pkg::CNTW'(pet_pkg::PRODW - 1);
          rem_d   = '0;
          phase_d = PH_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      PH_DIV: begin
        rem_d  = qbit ? pet_pkg::DW'(rem_sh - {1'b0, d_q}) : rem_sh[pet_pkg::DW-1:0];
        prod_d = {prod_q[pet_pkg::PRODW-2:0], qbit};
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    prod_q <= prod_d;
    d_q    <= d_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = (prod_q > pet_pkg::PRODW'(pet_pkg::LIMIT)) ? pet_pkg::LIMIT
                                                              : prod_q[pet_pkg::AW-1:0];

endmodule

@@ rtl/pet_datapath.sv @@
`timescale 1ns / 1ps
module pet_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pet_pkg::pet_cmd_t            cmd_i,
  output pet_pkg::pet_stat_t           stat_o,
  input  logic [31:0]                  cap_i,
  input  logic [15:0]                  bw_i,
  input  logic [27:0]                  freq_i,
  output logic [pet_pkg::POSW-1:0]     pos_o,
  output logic [pet_pkg::VELW-1:0]     vel_o,
  output logic [pet_pkg::TURNW-1:0]    turn_o,
  output logic                         bad_o
);

  logic [15:0]                     p_q, h_q;
  logic                            bad_q;
  logic signed [pet_pkg::SW-1:0]   diff_q, dest_q, err_q, corr_q, x_q;
  logic [pet_pkg::POSW-1:0]        pos_q;
  logic signed [pet_pkg::VELW-1:0] vel_q;
  logic [pet_pkg::TURNW-1:0]       turn_q;
  logic                            neg_q;
  logic [pet_pkg::POSW-1:0]        opos_q;
  logic [pet_pkg::VELW-1:0]        ovel_q;
  logic [pet_pkg::TURNW-1:0]       oturn_q;
  logic                            obad_q;

  logic [15:0]                     cap_p, cap_h;
  logic [pet_pkg::DW-1:0]          f_eff;
  logic [31:0]                     bwp, bw2;
  logic signed [pet_pkg::SW-1:0]   vel_ext, vel_mag, err_mag, x_mag;
  logic [pet_pkg::AW-1:0]          op_a;
  logic [pet_pkg::BW_B-1:0]        op_b;
  logic [pet_pkg::DW-1:0]          op_d;
  logic                            op_neg;
  logic                            mdiv_done;
  logic [pet_pkg::AW-1:0]          mdiv_res;
  logic signed [pet_pkg::SW-1:0]   sres, pos_ext, diff_raw, diff_w, err_raw, err_c;
  logic signed [pet_pkg::SW-1:0]   npos, nv, nv_c;
  logic [pet_pkg::TURNW-1:0]       turns;

  assign cap_p   = cap_i[15:0];
  assign cap_h   = cap_i[31:16];
  assign f_eff   = (freq_i == '0) ? pet_pkg::DW'(1) : freq_i;
  assign bwp     = 32'(bw_i) * 32'(p_q);
  assign bw2     = 32'(bw_i) * 32'(bw_i);
  assign vel_ext = pet_pkg::SW'(vel_q);
  assign vel_mag = vel_q[pet_pkg::VELW-1] ? -vel_ext : vel_ext;
  assign err_mag = err_q[pet_pkg::SW-1] ? -err_q : err_q;
  assign x_mag   = x_q[pet_pkg::SW-1] ? -x_q : x_q;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_d   = pet_pkg::DW'(1);
    op_neg = 1'b0;
    unique case (cmd_i.op)
      pet_pkg::OP_MEAS: begin
        op_a = pet_pkg::MEAS_A;
        op_b = pet_pkg::BW_B'(h_q);
        op_d = pet_pkg::DW'(p_q);
      end
      pet_pkg::OP_DEST: begin
        op_neg = vel_q[pet_pkg::VELW-1];
        op_a   = vel_mag[pet_pkg::AW-1:0];
        op_b   = pet_pkg::BW_B'({p_q, 8'b0});
        op_d   = f_eff;
      end
      pet_pkg::OP_CORR: begin
        op_neg = err_q[pet_pkg::SW-1];
        op_a   = err_mag[pet_pkg::AW-1:0];
        op_b   = {bwp, 1'b0};
        op_d   = f_eff;
      end
      pet_pkg::OP_X: begin
        op_neg = err_q[pet_pkg::SW-1];
        op_a   = err_mag[pet_pkg::AW-1:0];
        op_b   = pet_pkg::BW_B'(p_q);
        op_d   = f_eff;
      end
      pet_pkg::OP_DV: begin
        op_neg = x_q[pet_pkg::SW-1];
        op_a   = x_mag[pet_pkg::AW-1:0];
        op_b   = pet_pkg::BW_B'(bw2);
        op_d   = pet_pkg::VEL_DIV;
      end
      default: op_neg = 1'b0;
    endcase
  end

  pet_mdiv u_mdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .a_i     (op_a),
    .b_i     (op_b),
    .d_i     (op_d),
    .done_o  (mdiv_done),
    .res_o   (mdiv_res)
  );

  always_comb begin
    sres     = signed'(pet_pkg::SW'(mdiv_res));
    sres     = neg_q ? -sres : sres;
    pos_ext  = signed'(pet_pkg::SW'(pos_q));
    diff_raw = sres - pos_ext;
    if (diff_raw < -pet_pkg::HALF_S) begin
      diff_w = diff_raw + pet_pkg::TURN_S;
    end else if (diff_raw >= pet_pkg::HALF_S) begin
      diff_w = diff_raw - pet_pkg::TURN_S;
    end else begin
      diff_w = diff_raw;
    end
    err_raw = diff_q - sres;
    if (err_raw > pet_pkg::LIM_S) begin
      err_c = pet_pkg::LIM_S;
    end else if (err_raw < -pet_pkg::LIM_S) begin
      err_c = -pet_pkg::LIM_S;
    end else begin
      err_c = err_raw;
    end
    npos  = pos_ext + dest_q + corr_q;
    turns = {{(pet_pkg::TURNW - (pet_pkg::SW - pet_pkg::POSW)){npos[pet_pkg::SW-1]}},
             npos[pet_pkg::SW-1:pet_pkg::POSW]};
    nv    = vel_ext + sres;
    if (nv > pet_pkg::VMAX_S) begin
      nv_c = pet_pkg::VMAX_S;
    end else if (nv < pet_pkg::VMIN_S) begin
      nv_c = pet_pkg::VMIN_S;
    end else begin
      nv_c = nv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      vel_q  <= '0;
      turn_q <= '0;
    end else if (cmd_i.latch && cmd_i.op == pet_pkg::OP_DV) begin
      pos_q  <= npos[pet_pkg::POSW-1:0];
      vel_q  <= nv_c[pet_pkg::VELW-1:0];
      turn_q <= turn_q + turns;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q   <= cap_p;
      h_q   <= (cap_h > cap_p) ? cap_p : cap_h;
      bad_q <= (cap_p == '0);
    end
    if (cmd_i.start) begin
      neg_q <= op_neg;
    end
    if (cmd_i.latch) begin
      case (cmd_i.op)
        pet_pkg::OP_MEAS: diff_q <= diff_w;
        pet_pkg::OP_DEST: begin
          dest_q <= sres;
          err_q  <= err_c;
        end
        pet_pkg::OP_CORR: corr_q <= sres;
        pet_pkg::OP_X:    x_q    <= sres;
        default:          x_q    <= x_q;
      endcase
    end
    if (cmd_i.push) begin
      opos_q  <= pos_q;
      ovel_q  <= vel_q;
      oturn_q <= turn_q;
      obad_q  <= bad_q;
    end
  end

  assign stat_o.done        = mdiv_done;
  assign stat_o.period_zero = bad_q;
  assign pos_o  = opos_q;
  assign vel_o  = ovel_q;
  assign turn_o = oturn_q;
  assign bad_o  = obad_q;

endmodule

@@ rtl/pet_ctrl.sv @@
`timescale 1ns / 1ps
module pet_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output pet_pkg::pet_cmd_t   cmd_o,
  input  pet_pkg::pet_stat_t  stat_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] op_q, op_d;
  logic       m_valid_q, m_valid_d;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cmd_o     = '0;
    cmd_o.op  = op_q;
    m_valid_d = m_valid_q && !m_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        op_d    = pet_pkg::OP_MEAS;
        state_d = stat_i.period_zero ? ST_PUSH : ST_START;
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat_i.done) begin
          cmd_o.latch = 1'b1;
          if (op_q == pet_pkg::OP_DV) begin
            state_d = ST_PUSH;
          end else begin
            op_d    = op_q + 1'b1;
            state_d = ST_START;
          end
        end
      end
      ST_PUSH: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.push = 1'b1;
          m_valid_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= pet_pkg::OP_MEAS;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (!m_valid_q || m_ready_i))
    else $error("word pushed over an untaken result");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> !stat_i.done)
    else $error("done still set after start");

  a_wait_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && stat_i.done) |=> (state_q == ST_START || state_q == ST_PUSH))
    else $error("bad exit from wait");

endmodule

@@ rtl/pwm_encoder_pll_tracker.sv @@
`timescale 1ns / 1ps
// PWM encoder tracking loop.
// Input stream: one word per encoder PWM capture (period and high time in
// timer ticks). Output stream: one word per capture with the wrapped
// position (Q12.16), velocity (Q24.8 counts/s) and turn count, plus a
// bad-capture flag in tuser for a zero period (state left as it was).
// APB port: loop bandwidth at 0x0, timer frequency at 0x4; write only while
// no capture is in flight.
// A valid capture goes from acceptance to the output register through five
// passes of one shared multiply-divide unit (33 shift-add steps plus 76
// restoring-divide steps each, with a start command before and a latch after
// each pass). A zero-period capture skips the unit and goes straight to the
// output register. One capture is worked at a time.
// The output register holds a finished word while the receiver stalls; the
// next capture is accepted meanwhile, and its result waits until the held
// word is taken.
// Reset clears position, velocity, turn count and the output valid, and
// loads bandwidth 1000 and timer frequency 53333333.
module pwm_encoder_pll_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // capture_period, capture_high
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,  // position_counts, velocity_counts, turn_count
  output logic        m_axis_tuser_o,  // bad_capture
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]                   bw_q;
  logic [27:0]                   freq_q;
  pet_pkg::pet_cmd_t             cmd;
  pet_pkg::pet_stat_t            stat;
  logic [pet_pkg::POSW-1:0]      pos;
  logic [pet_pkg::VELW-1:0]      vel;
  logic [pet_pkg::TURNW-1:0]     turn;
  logic                          bad;
  logic                          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q   <= 16'd1000;
      freq_q <= 28'd53333333;
    end else if (wr_en) begin
      if (paddr[2]) begin
        freq_q <= pwdata[27:0];
      end else begin
        bw_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = paddr[2] ? {4'b0, freq_q} : {16'b0, bw_q};

  pet_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  pet_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .cap_i  (s_axis_tdata_i),
    .bw_i   (bw_q),
    .freq_i (freq_q),
    .pos_o  (pos),
    .vel_o  (vel),
    .turn_o (turn),
    .bad_o  (bad)
  );

  assign m_axis_tdata_o = {4'b0, turn, vel, pos};
  assign m_axis_tuser_o = bad;

endmodule

@@ tb/sv/tb_pwm_encoder_pll_tracker.sv @@
`timescale 1ns / 1ps
module tb_pwm_encoder_pll_tracker;

  localparam longint unsigned SAT_LIM   = 64'd1 << 42;
  localparam longint          TURN_SPAN = 64'sd268435456;
  localparam int              IDLE_LIM  = 20000;
  localparam logic [2:0]      ADDR_BW   = 3'd0;
  localparam logic [2:0]      ADDR_FREQ = 3'd4;

  typedef struct {
    logic [27:0] position;
    logic [31:0] velocity;
    logic [31:0] turns;
    logic        bad;
  } track_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [95:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pwm_encoder_pll_tracker uut (.*);

  track_word_t     track_q[$];
  logic [27:0]     est_pos;
  logic [31:0]     est_vel;
  logic [31:0]     est_turns;
  logic [15:0]     bw_reg;
  logic [27:0]     freq_reg;
  int              errors;
  int              idle_cycles;
  bit              stall_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned mul_div_sat(longint unsigned a, longint unsigned b,
                                                  longint unsigned d);
    longint unsigned q, r, s;
    if (d == 0) return SAT_LIM;
    if (a > SAT_LIM) a = SAT_LIM;
    q = a / d;
    r = a % d;
    if (b != 0 && q > SAT_LIM / b) return SAT_LIM;
    s = q * b + (r * b) / d;
    return (s > SAT_LIM) ? SAT_LIM : s;
  endfunction

  function automatic longint scale_signed(longint x, longint unsigned b, longint unsigned d);
    longint unsigned mag, r;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    r = mul_div_sat(mag, b, d);
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_sat(longint x);
    if (x > longint'(SAT_LIM)) return longint'(SAT_LIM);
    if (x < -longint'(SAT_LIM)) return -longint'(SAT_LIM);
    return x;
  endfunction

  task automatic track_capture(input logic [15:0] period, input logic [15:0] high_t);
    longint unsigned p, h, f, bw;
    longint pos, vel, meas, diff, dest, err, corr, npos, nturns, x, dv, nv;
    track_word_t w;
    p = period;
    h = high_t;
    if (h > p) h = p;
    w.bad = (p == 0);
    if (p != 0) begin
      f = (freq_reg != 0) ? longint'(freq_reg) : 1;
      bw = bw_reg;
      pos = longint'(est_pos);
      vel = longint'($signed(est_vel));
      meas = longint'(mul_div_sat(TURN_SPAN, h, p));
      diff = meas - pos;
      if (diff < -(TURN_SPAN / 2)) diff += TURN_SPAN;
      else if (diff >= TURN_SPAN / 2) diff -= TURN_SPAN;
      dest = scale_signed(vel, p << 8, f);
      err = clamp_sat(diff - dest);
      corr = scale_signed(err, 2 * bw * p, f);
      npos = pos + dest + corr;
      nturns = npos / TURN_SPAN;
      npos = npos % TURN_SPAN;
      if (npos < 0) begin
        npos += TURN_SPAN;
        nturns -= 1;
      end
      est_pos = npos[27:0];
      est_turns = est_turns + nturns[31:0];
      x = scale_signed(err, p, f);
      dv = scale_signed(x, bw * bw, 256);
      nv = vel + dv;
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      if (nv < -64'sd2147483648) nv = -64'sd2147483648;
      est_vel = nv[31:0];
    end
    w.position = est_pos;
    w.velocity = est_vel;
    w.turns = est_turns;
    track_q.push_back(w);
  endtask

  task automatic send_capture(input logic [15:0] period, input logic [15:0] high_t);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i <= {high_t, period};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    track_capture(period, high_t);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    while (track_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_BW) bw_reg = data[15:0];
    else freq_reg = data[27:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_gains(input logic [31:0] bw, input logic [31:0] freq);
    wait_drain();
    apb_write(ADDR_BW, bw);
    apb_write(ADDR_FREQ, freq);
  endtask

  task automatic test_reset_defaults();
    send_capture(16'd53333, 16'd0);
    send_capture(16'd53333, 16'd13333);
    send_capture(16'd0, 16'd100);
    send_capture(16'd0, 16'hFFFF);
  endtask

  task automatic test_directed_edges();
    send_capture(16'd1000, 16'd2000);
    send_capture(16'd1, 16'd1);
    send_capture(16'd1, 16'd0);
    send_capture(16'hFFFF, 16'hFFFF);
    send_capture(16'hFFFF, 16'd0);
    send_capture(16'd2, 16'd1);
    send_capture(16'd4096, 16'd2048);
    send_capture(16'd53333, 16'd26666);
    send_capture(16'd53333, 16'd53000);
    send_capture(16'd53333, 16'd100);
    send_capture(16'd0, 16'd0);
  endtask

  task automatic test_gain_extremes();
    set_gains(32'd0, 32'd1);
    send_capture(16'd50000, 16'd12500);
    send_capture(16'hFFFF, 16'h7FFF);
    send_capture(16'd3, 16'd2);
    set_gains(32'd65535, 32'd1);
    send_capture(16'hFFFF, 16'd40000);
    send_capture(16'd1, 16'd1);
    send_capture(16'hFFFF, 16'd100);
    set_gains(32'd65535, 32'd200000000);
    send_capture(16'd53333, 16'd1000);
    send_capture(16'd53333, 16'd40000);
    set_gains(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_capture(16'd8000, 16'd4000);
    set_gains(32'd0, 32'd0);
    send_capture(16'd8000, 16'd1000);
  endtask

  task automatic test_random_tracking(input int count);
    int unsigned angle, step, period, high_t;
    angle = $urandom_range(0, 65535);
    step = $urandom_range(0, 3000);
    period = $urandom_range(20000, 65535);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        angle = (angle + step) % 65536;
        if ($urandom_range(0, 30) == 0) step = $urandom_range(0, 8000);
        if ($urandom_range(0, 30) == 0) period = $urandom_range(1, 65535);
        high_t = (angle * period) / 65536;
        send_capture(period[15:0], high_t[15:0]);
      end else if ($urandom_range(0, 9) < 2) begin
        send_capture(16'd0, 16'($urandom_range(0, 65535)));
      end else begin
        send_capture(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    stall_on = 1'b0;
    m_axis_tready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!stall_on) m_axis_tready_i <= 1'b1;
      else if ($urandom_range(0, 99) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(50, 400)) @(negedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  always @(posedge clk_i) begin
    track_word_t w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (track_q.size() == 0) begin
        $display("%0t: unexpected word %h user %b", $time, m_axis_tdata_o, m_axis_tuser_o);
        errors++;
      end else begin
        w = track_q.pop_front();
        if (m_axis_tdata_o[27:0] !== w.position) begin
          $display("%0t: position exp %h got %h", $time, w.position, m_axis_tdata_o[27:0]);
          errors++;
        end
        if (m_axis_tdata_o[59:28] !== w.velocity) begin
          $display("%0t: velocity exp %h got %h", $time, w.velocity, m_axis_tdata_o[59:28]);
          errors++;
        end
        if (m_axis_tdata_o[91:60] !== w.turns) begin
          $display("%0t: turns exp %h got %h", $time, w.turns, m_axis_tdata_o[91:60]);
          errors++;
        end
        if (m_axis_tuser_o !== w.bad) begin
          $display("%0t: bad_capture exp %b got %b", $time, w.bad, m_axis_tuser_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIM) begin
      $display("FAIL pwm_encoder_pll_tracker");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    est_pos = '0;
    est_vel = '0;
    est_turns = '0;
    bw_reg = 16'd1000;
    freq_reg = 28'd53333333;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_directed_edges();
    stall_on = 1'b1;
    test_gain_extremes();
    set_gains(32'd1000, 32'd53333333);
    test_random_tracking(250);
    set_gains($urandom_range(1, 65535), $urandom_range(1000000, 200000000));
    test_random_tracking(200);
    stall_on = 1'b0;
    set_gains($urandom_range(0, 4000), $urandom_range(1, 200000000));
    test_random_tracking(100);
    stall_on = 1'b1;
    set_gains(32'd200, 32'd16000000);
    test_random_tracking(150);
    wait_drain();
    if (errors == 0)
      $display("PASS pwm_encoder_pll_tracker");
    else
      $display("FAIL pwm_encoder_pll_tracker");
    $finish;
  end

endmodule
